### hdl/qti_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the
// efficiency table interpolator. No dependencies.
package qti_pkg;

    // Table geometry
    localparam int NUM_PIXELS  = 16;
    localparam int TABLE_DEPTH = 64;
    localparam int MEM_DEPTH   = NUM_PIXELS * TABLE_DEPTH;
    localparam int PIX_W       = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int ENTRY_W     = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int PIXEL_W   = 5;
    localparam int INDEX_W   = 6;
    localparam int VAL_W     = 16;
    localparam int LAM_W     = 16;
    localparam int LAST_W    = 17;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Derived arithmetic widths
    localparam int SPAN_W    = LEN_W + LAM_W;
    localparam int SUM_W     = SPAN_W + 1;
    localparam int DIV_W     = 2 * VAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int LAST_MAX  = (2 ** LAST_W) - 1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY_PIX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY_ENV = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PIXEL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CE_WITH_FIELD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CE_NO_FIELD   = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_LAMBDA_FIRST = 16'd4800;
    localparam logic [CFG_W-1:0] RST_LAMBDA_STEP  = 16'd32;
    localparam logic [CFG_W-1:0] RST_CE           = 16'hFFFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic                take_input;
        logic                load_write;
        logic                len_pick;
        logic                len_clear;
        logic                len_max;
        logic                span_calc;
        logic                range_calc;
        logic                div_idx_start;
        logic                idx_capture;
        logic                cnt_clear;
        logic                cnt_inc;
        logic                acc_clear;
        logic                rd_issue;
        logic                prod_calc;
        logic                div_frac_start;
        logic                qe_from_div;
        logic                qe_from_acc;
        logic                ce_calc;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                out_load;
    } qti_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pix_ok;
        logic              idx_ok;
        logic              len_zero;
        logic              out_of_range;
        logic              div_busy;
        logic              div_done;
        logic              r_zero;
        logic              cnt_last;
    } qti_stat_t;

endpackage

### hdl/qti_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on qti_pkg.
module qti_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        half,
    input  logic [qti_pkg::DIV_W-1:0]   dividend,
    input  logic [qti_pkg::VAL_W-1:0]   divisor,
    output logic [qti_pkg::DIV_W-1:0]   quotient,
    output logic [qti_pkg::VAL_W-1:0]   remainder,
    output logic                        busy,
    output logic                        done
);

    logic [qti_pkg::DIV_W-1:0]     quo_reg;
    logic [qti_pkg::VAL_W-1:0]     rem_reg;
    logic [qti_pkg::VAL_W-1:0]     dvs_reg;
    logic [qti_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [qti_pkg::VAL_W:0]       shifted;
    logic [qti_pkg::VAL_W:0]       trial;
    logic                          fits;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[qti_pkg::DIV_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Iterate; a half run expects the dividend already shifted to the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= half ? qti_pkg::DIV_CNT_W'(qti_pkg::DIV_W / 2 - 1)
                                 : qti_pkg::DIV_CNT_W'(qti_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - qti_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[qti_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? trial[qti_pkg::VAL_W-1:0] : shifted[qti_pkg::VAL_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

    // A new division never starts on top of a running one
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

### hdl/qti_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration, curve memory, lengths, interpolation arithmetic
// and result registers. Depends on qti_pkg and qti_div.
module qti_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [qti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qti_pkg::CFG_W-1:0]       cfg_data,
    input  logic [qti_pkg::FUNC_W-1:0]      func,
    input  logic [qti_pkg::PIXEL_W-1:0]     pixel,
    input  logic [qti_pkg::INDEX_W-1:0]     entry_index,
    input  logic [qti_pkg::VAL_W-1:0]       entry_value,
    input  logic                            entry_last,
    input  logic [qti_pkg::LAM_W-1:0]       wavelength,
    input  logic                            field_on,
    input  qti_pkg::qti_cmd_t               cmd,
    output qti_pkg::qti_stat_t              stat,
    output logic [qti_pkg::VAL_W-1:0]       qe_value,
    output logic [qti_pkg::VAL_W-1:0]       efficiency,
    output logic [qti_pkg::LAST_W-1:0]      lambda_last,
    output logic [qti_pkg::STATUS_W-1:0]    status
);

    // Configuration registers
    logic [qti_pkg::CFG_W-1:0] first_reg;
    logic [qti_pkg::CFG_W-1:0] step_reg;
    logic [qti_pkg::CFG_W-1:0] ce_on_reg;
    logic [qti_pkg::CFG_W-1:0] ce_off_reg;

    // Captured item
    logic [qti_pkg::FUNC_W-1:0]  func_reg;
    logic [qti_pkg::PIXEL_W-1:0] pixel_reg;
    logic [qti_pkg::INDEX_W-1:0] index_reg;
    logic [qti_pkg::VAL_W-1:0]   value_reg;
    logic                        last_flag_reg;
    logic [qti_pkg::LAM_W-1:0]   wave_reg;
    logic                        field_reg;

    // Curve storage
    logic [qti_pkg::VAL_W-1:0] mem [qti_pkg::MEM_DEPTH];
    logic [qti_pkg::LEN_W-1:0] curve_len_reg [qti_pkg::NUM_PIXELS];

    // Working registers
    logic [qti_pkg::LEN_W-1:0]   n_reg;
    logic [qti_pkg::SPAN_W-1:0]  span_reg;
    logic [qti_pkg::PIX_W-1:0]   cnt_reg;
    logic [qti_pkg::ENTRY_W-1:0] a0_reg;
    logic [qti_pkg::ENTRY_W-1:0] a1_reg;
    logic [qti_pkg::LAM_W-1:0]   r_reg;
    logic [qti_pkg::VAL_W-1:0]   rd0_reg;
    logic [qti_pkg::VAL_W-1:0]   rd1_reg;
    logic                        m0_reg;
    logic                        m1_reg;
    logic                        rd_valid_reg;
    logic [qti_pkg::VAL_W-1:0]   acc0_reg;
    logic [qti_pkg::VAL_W-1:0]   acc1_reg;
    logic [qti_pkg::DIV_W-1:0]   p0_reg;
    logic [qti_pkg::DIV_W-1:0]   p1_reg;
    logic [qti_pkg::VAL_W-1:0]   qe_reg;
    logic [qti_pkg::DIV_W-1:0]   eff_reg;
    logic [qti_pkg::LAST_W-1:0]  last_reg;
    logic [qti_pkg::STATUS_W-1:0] st_reg;

    // Output registers
    logic [qti_pkg::VAL_W-1:0]    qe_out_reg;
    logic [qti_pkg::VAL_W-1:0]    eff_out_reg;
    logic [qti_pkg::LAST_W-1:0]   last_out_reg;
    logic [qti_pkg::STATUS_W-1:0] st_out_reg;

    // Combinational helpers
    logic [qti_pkg::PIXEL_W-1:0] pix_m1;
    logic [qti_pkg::PIX_W-1:0]   pix_idx;
    logic [qti_pkg::PIX_W-1:0]   rd_pix;
    logic                        is_env;
    logic [qti_pkg::LAM_W-1:0]   step_eff;
    logic [qti_pkg::LEN_W-1:0]   n_m1;
    logic [qti_pkg::LEN_W-1:0]   len_sel;
    logic [qti_pkg::SPAN_W-1:0]  span_next;
    logic [qti_pkg::SUM_W-1:0]   last_sum;
    logic [qti_pkg::LAM_W-1:0]   d_val;
    logic [qti_pkg::ADDR_W-1:0]  wr_addr;
    logic [qti_pkg::ADDR_W-1:0]  rd_addr0;
    logic [qti_pkg::ADDR_W-1:0]  rd_addr1;
    logic [qti_pkg::VAL_W-1:0]   v0;
    logic [qti_pkg::VAL_W-1:0]   v1;
    logic [qti_pkg::LAM_W-1:0]   step_diff;
    logic [qti_pkg::DIV_W-1:0]   p0_next;
    logic [qti_pkg::DIV_W-1:0]   p1_next;
    logic [qti_pkg::DIV_W-1:0]   frac_sum;
    logic [qti_pkg::VAL_W-1:0]   ce_sel;
    logic [qti_pkg::DIV_W-1:0]   eff_next;

    // Divider interface
    logic                        div_start;
    logic                        div_half;
    logic [qti_pkg::DIV_W-1:0]   div_dividend;
    logic [qti_pkg::DIV_W-1:0]   div_quo;
    logic [qti_pkg::VAL_W-1:0]   div_rem;
    logic                        div_busy;
    logic                        div_done;

    function automatic logic [qti_pkg::ADDR_W-1:0] mem_addr(
        input logic [qti_pkg::PIX_W-1:0]   pix,
        input logic [qti_pkg::ENTRY_W-1:0] entry
    );
        logic [qti_pkg::ADDR_W-1:0] base;
        base = qti_pkg::ADDR_W'(pix) * qti_pkg::ADDR_W'(qti_pkg::TABLE_DEPTH);
        return base + qti_pkg::ADDR_W'(entry);
    endfunction

    // Decode captured item and derive addresses
    always_comb
    begin
        pix_m1    = pixel_reg - qti_pkg::PIXEL_W'(1);
        pix_idx   = qti_pkg::PIX_W'(pix_m1);
        is_env    = (func_reg == qti_pkg::FUNC_QUERY_ENV);
        rd_pix    = is_env ? cnt_reg : pix_idx;
        len_sel   = curve_len_reg[rd_pix];
        step_eff  = (step_reg == '0) ? qti_pkg::LAM_W'(1) : step_reg;
        n_m1      = n_reg - qti_pkg::LEN_W'(1);
        span_next = qti_pkg::SPAN_W'(n_m1) * qti_pkg::SPAN_W'(step_eff);
        last_sum  = qti_pkg::SUM_W'(first_reg) + qti_pkg::SUM_W'(span_reg);
        d_val     = wave_reg - first_reg;
        wr_addr   = mem_addr(pix_idx, qti_pkg::ENTRY_W'(index_reg));
        rd_addr0  = mem_addr(rd_pix, a0_reg);
        rd_addr1  = mem_addr(rd_pix, a1_reg);
        v0        = m0_reg ? rd0_reg : '0;
        v1        = m1_reg ? rd1_reg : '0;
        step_diff = step_eff - r_reg;
        p0_next   = qti_pkg::DIV_W'(acc0_reg) * qti_pkg::DIV_W'(step_diff);
        p1_next   = qti_pkg::DIV_W'(acc1_reg) * qti_pkg::DIV_W'(r_reg);
        frac_sum  = p0_reg + p1_reg;
        ce_sel    = field_reg ? ce_on_reg : ce_off_reg;
        eff_next  = qti_pkg::DIV_W'(qe_reg) * qti_pkg::DIV_W'(ce_sel);
    end

    // Status toward the controller
    always_comb
    begin
        stat.func         = func_reg;
        stat.pix_ok       = (pixel_reg != '0) && (32'(pixel_reg) <= qti_pkg::NUM_PIXELS);
        stat.idx_ok       = (32'(index_reg) < qti_pkg::TABLE_DEPTH);
        stat.len_zero     = (n_reg == '0);
        stat.out_of_range = (wave_reg < first_reg) ||
                            (qti_pkg::SPAN_W'(d_val) > span_reg);
        stat.div_busy     = div_busy;
        stat.div_done     = div_done;
        stat.r_zero       = (r_reg == '0);
        stat.cnt_last     = is_env ? (cnt_reg == qti_pkg::PIX_W'(qti_pkg::NUM_PIXELS - 1))
                                   : 1'b1;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= qti_pkg::RST_LAMBDA_FIRST;
            step_reg   <= qti_pkg::RST_LAMBDA_STEP;
            ce_on_reg  <= qti_pkg::RST_CE;
            ce_off_reg <= qti_pkg::RST_CE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                qti_pkg::CFG_LAMBDA_FIRST:  first_reg  <= cfg_data;
                qti_pkg::CFG_LAMBDA_STEP:   step_reg   <= cfg_data;
                qti_pkg::CFG_CE_WITH_FIELD: ce_on_reg  <= cfg_data;
                qti_pkg::CFG_CE_NO_FIELD:   ce_off_reg <= cfg_data;
                default:                    first_reg  <= first_reg;
            endcase
        end
    end

    // Curve lengths: cleared by reset, set by a load with the last flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < qti_pkg::NUM_PIXELS; p++)
            begin
                curve_len_reg[p] <= '0;
            end
        end
        else if (cmd.load_write && last_flag_reg)
        begin
            curve_len_reg[pix_idx] <= qti_pkg::LEN_W'(index_reg) + qti_pkg::LEN_W'(1);
        end
    end

    // Curve memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            mem[wr_addr] <= value_reg;
        end
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
    end

    // Read pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_issue;
        end
    end

    // Capture the item and run the interpolation steps
    always_ff @(posedge clk)
    begin
        if (cmd.take_input)
        begin
            func_reg      <= func;
            pixel_reg     <= pixel;
            index_reg     <= entry_index;
            value_reg     <= entry_value;
            last_flag_reg <= entry_last;
            wave_reg      <= wavelength;
            field_reg     <= field_on;
            qe_reg        <= '0;
            eff_reg       <= '0;
            last_reg      <= '0;
            st_reg        <= qti_pkg::ST_OK;
        end

        // Curve length: one pixel, or running max over a sweep
        if (cmd.len_pick)
        begin
            n_reg <= len_sel;
        end
        else if (cmd.len_clear)
        begin
            n_reg <= '0;
        end
        else if (cmd.len_max && (len_sel > n_reg))
        begin
            n_reg <= len_sel;
        end

        // Pixel sweep counter
        if (cmd.cnt_clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + qti_pkg::PIX_W'(1);
        end

        if (cmd.span_calc)
        begin
            span_reg <= span_next;
        end

        // Last covered wavelength, saturated
        if (cmd.range_calc)
        begin
            last_reg <= (last_sum > qti_pkg::SUM_W'(qti_pkg::LAST_MAX))
                        ? qti_pkg::LAST_W'(qti_pkg::LAST_MAX)
                        : qti_pkg::LAST_W'(last_sum);
        end

        // Table position; past the last interval, use the last entry exactly
        if (cmd.idx_capture)
        begin
            if (div_quo >= qti_pkg::DIV_W'(n_m1))
            begin
                a0_reg <= qti_pkg::ENTRY_W'(n_m1);
                a1_reg <= qti_pkg::ENTRY_W'(n_m1) + qti_pkg::ENTRY_W'(1);
                r_reg  <= '0;
            end
            else
            begin
                a0_reg <= qti_pkg::ENTRY_W'(div_quo);
                a1_reg <= qti_pkg::ENTRY_W'(div_quo) + qti_pkg::ENTRY_W'(1);
                r_reg  <= div_rem;
            end
        end

        // Entry mask: only entries below the pixel's length count
        if (cmd.rd_issue)
        begin
            m0_reg <= (len_sel > qti_pkg::LEN_W'(a0_reg));
            m1_reg <= (len_sel > (qti_pkg::LEN_W'(a0_reg) + qti_pkg::LEN_W'(1)));
        end

        // Max accumulation of the two neighbor samples
        if (cmd.acc_clear)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            if (v0 > acc0_reg)
            begin
                acc0_reg <= v0;
            end
            if (v1 > acc1_reg)
            begin
                acc1_reg <= v1;
            end
        end

        if (cmd.prod_calc)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end

        if (cmd.qe_from_div)
        begin
            qe_reg <= qti_pkg::VAL_W'(div_quo);
        end
        else if (cmd.qe_from_acc)
        begin
            qe_reg <= acc0_reg;
        end

        if (cmd.ce_calc)
        begin
            eff_reg <= eff_next;
        end

        if (cmd.set_status)
        begin
            st_reg <= cmd.status_code;
        end

        // Output register
        if (cmd.out_load)
        begin
            qe_out_reg   <= qe_reg;
            eff_out_reg  <= eff_reg[qti_pkg::DIV_W-1:qti_pkg::VAL_W];
            last_out_reg <= last_reg;
            st_out_reg   <= st_reg;
        end
    end

    // Shared divider: index step (half length) and fraction (full length)
    assign div_start    = cmd.div_idx_start | cmd.div_frac_start;
    assign div_half     = cmd.div_idx_start;
    assign div_dividend = cmd.div_idx_start ? {d_val, {qti_pkg::VAL_W{1'b0}}}
                                            : frac_sum;

    qti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .half      (div_half),
        .dividend  (div_dividend),
        .divisor   (step_eff),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    assign qe_value    = qe_out_reg;
    assign efficiency  = eff_out_reg;
    assign lambda_last = last_out_reg;
    assign status      = st_out_reg;

endmodule

### hdl/qti_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences one item through the datapath and
// owns the input and output handshakes. Depends on qti_pkg.
module qti_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  qti_pkg::qti_stat_t  stat,
    output qti_pkg::qti_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_ENVLEN = 4'd2;
    localparam logic [3:0] S_LENCHK = 4'd3;
    localparam logic [3:0] S_RANGE  = 4'd4;
    localparam logic [3:0] S_DIV1   = 4'd5;
    localparam logic [3:0] S_FETCH  = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_DIV2   = 4'd10;
    localparam logic [3:0] S_CE     = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_input = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.func)
                    qti_pkg::FUNC_LOAD:
                    begin
                        if (stat.pix_ok && stat.idx_ok)
                        begin
                            cmd.load_write = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = qti_pkg::ST_BAD_PIXEL;
                        end
                        state_next = S_RESULT;
                    end
                    qti_pkg::FUNC_QUERY_PIX:
                    begin
                        if (stat.pix_ok)
                        begin
                            cmd.len_pick = 1'b1;
                            state_next   = S_LENCHK;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = qti_pkg::ST_BAD_PIXEL;
                            state_next      = S_RESULT;
                        end
                    end
                    qti_pkg::FUNC_QUERY_ENV:
                    begin
                        cmd.len_clear = 1'b1;
                        cmd.cnt_clear = 1'b1;
                        state_next    = S_ENVLEN;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_ENVLEN:
            begin
                // Sweep pixel lengths for the envelope length
                cmd.len_max = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_LENCHK;
                end
            end
            S_LENCHK:
            begin
                if (stat.len_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = qti_pkg::ST_EMPTY;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.span_calc = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    cmd.acc_clear = 1'b1;
                    state_next    = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.range_calc = 1'b1;
                if (stat.out_of_range)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = qti_pkg::ST_RANGE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.div_idx_start = 1'b1;
                    state_next        = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (stat.div_done)
                begin
                    cmd.idx_capture = 1'b1;
                    state_next      = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // Read the neighbor entries of one pixel per cycle
                cmd.rd_issue = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (stat.r_zero)
                begin
                    cmd.qe_from_acc = 1'b1;
                    state_next      = S_CE;
                end
                else
                begin
                    cmd.prod_calc = 1'b1;
                    state_next    = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.div_frac_start = 1'b1;
                state_next         = S_DIV2;
            end
            S_DIV2:
            begin
                if (stat.div_done)
                begin
                    cmd.qe_from_div = 1'b1;
                    state_next      = S_CE;
                end
            end
            S_CE:
            begin
                cmd.ce_calc = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                // Hold until the output register has room
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");

    // A new result only appears out of the result state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside result state");

    // Waiting on the divider only while it works or has just finished
    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV1 || state_reg == S_DIV2) |-> (stat.div_busy || stat.div_done))
        else $error("waiting on an idle divider");

endmodule

### hdl/qe_table_interpolator_core.sv
`timescale 1ns / 1ps
// Top level of the efficiency table interpolator: controller plus datapath.
// Depends on qti_pkg, qti_ctrl and qti_dp (which holds qti_div).
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------------
//  cfg      cfg_write              cfg_index, cfg_data
//  in       in_valid / in_stall    func, pixel, entry_index, entry_value,
//                                  entry_last, wavelength, field_on
//  out      out_valid / out_stall  qe_value, efficiency, lambda_last, status
//
// One item at a time. A load or an error caught at decode goes straight to the
// result state; a pixel query on a grid point skips the interpolation
// fraction; an envelope query adds two 16-pixel sweeps (lengths, then table
// reads on the memory's two ports). The shared bit-serial divider sets most of
// the query time: a half run for the table position, a full run for the
// interpolation fraction. Reset clears lengths and control and presets the
// configuration; the curve memory is not cleared. A new item is taken while a
// result waits under out_stall.
module qe_table_interpolator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [qti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qti_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [qti_pkg::FUNC_W-1:0]      func,
    input  logic [qti_pkg::PIXEL_W-1:0]     pixel,
    input  logic [qti_pkg::INDEX_W-1:0]     entry_index,
    input  logic [qti_pkg::VAL_W-1:0]       entry_value,
    input  logic                            entry_last,
    input  logic [qti_pkg::LAM_W-1:0]       wavelength,
    input  logic                            field_on,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [qti_pkg::VAL_W-1:0]       qe_value,
    output logic [qti_pkg::VAL_W-1:0]       efficiency,
    output logic [qti_pkg::LAST_W-1:0]      lambda_last,
    output logic [qti_pkg::STATUS_W-1:0]    status
);

    qti_pkg::qti_cmd_t  cmd;
    qti_pkg::qti_stat_t stat;

    qti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    qti_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .pixel       (pixel),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .entry_last  (entry_last),
        .wavelength  (wavelength),
        .field_on    (field_on),
        .cmd         (cmd),
        .stat        (stat),
        .qe_value    (qe_value),
        .efficiency  (efficiency),
        .lambda_last (lambda_last),
        .status      (status)
    );

endmodule
